@@ hdl/csp_pkg.sv @@
// Shared types, constants and helper functions of the circle segment push-out block.
package csp_pkg;

   localparam int MAX_WALLS_DEFAULT = 64;

   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W = 31;
   localparam logic [CSR_INDEX_W-1:0] CSR_RADIUS = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WALL_COUNT = 2'd1;

   localparam logic FUNC_WRITE = 1'b0;
   localparam logic FUNC_RESOLVE = 1'b1;

   localparam int ITER_STEPS = 34;
   localparam int NUM_W = 100;
   localparam int DEN_W = 66;

   typedef enum logic {
      ITER_DIV,
      ITER_SQRT
   } iter_mode_type;

   typedef struct packed {
      logic          start;
      iter_mode_type mode;
   } iter_ctl_type;

   typedef struct packed {
      logic busy;
      logic done;
   } iter_sts_type;

   typedef struct packed {
      logic               func;
      logic [5:0]         wall_slot;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic               solid;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
   } req_type;

   typedef struct packed {
      logic signed [31:0] resolved_x;
      logic signed [31:0] resolved_y;
      logic               hit;
   } rsp_type;

   typedef struct packed {
      logic signed [31:0] ax;
      logic signed [31:0] ay;
      logic signed [31:0] bx;
      logic signed [31:0] by;
      logic               solid;
   } wall_type;

   function automatic logic [33:0] mag34(logic signed [33:0] v);
      logic [33:0] r;
      r = v[33] ? 34'(-v) : 34'(v);
      return r;
   endfunction

   function automatic logic signed [31:0] sat32(logic signed [34:0] v);
      logic signed [31:0] r;
      if (v > 35'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -35'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = v[31:0];
      end
      return r;
   endfunction

endpackage

@@ hdl/circle_segment_pushout.sv @@
// Top level of the circle segment push-out block: wall table, sequencer and result register.
// A write transaction stores one wall in the table in the cycle it is accepted. A resolve
// transaction walks slots 0 to wall_count-1 of the table in order, with wall_count capped at
// MAX_WALLS. A slot that is not solid is skipped; for a solid wall the closest point is found,
// with two divisions when it lies inside the segment. A penetrated wall adds one square root,
// two push divisions and one apply step, and one more square root when the centre sits on the
// wall line. A resolve ends with a final slot check and the result hand-off. All divides and
// square roots run on the single shared 34-step divide and square-root unit, and the table
// read is registered. The table is not cleared by reset; a resolve must only visit slots that
// were written.
module circle_segment_pushout #(
   parameter int MAX_WALLS = csp_pkg::MAX_WALLS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  csp_pkg::req_type                    req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output csp_pkg::rsp_type                    rsp_data,
   input  logic                                csr_we,
   input  logic [csp_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [csp_pkg::CSR_DATA_W-1:0]      csr_wdata
);

   localparam int AW = (MAX_WALLS > 1) ? $clog2(MAX_WALLS) : 1;
   localparam int CW = $clog2(MAX_WALLS + 1);

   typedef enum logic [4:0] {
      S_IDLE, S_FETCH, S_CHECK, S_LXX, S_LYY, S_DX, S_DY, S_DSUM, S_CLOSE,
      S_OLO, S_OHI, S_ODIV, S_OWAIT, S_EX, S_EY, S_RR, S_HIT, S_DWAIT,
      S_NWAIT, S_PMUL, S_PDIV, S_PWAIT, S_APPLY, S_DONE
   } state_type;

   csp_pkg::wall_type mem [MAX_WALLS];

   state_type                 state_ff;
   logic [30:0]               radius_ff;
   logic [6:0]                count_ff;
   logic [CW-1:0]             idx_ff;
   csp_pkg::wall_type         rd_ff;
   logic signed [31:0]        px_ff;
   logic signed [31:0]        py_ff;
   logic                      hit_ff;
   logic [67:0]               prod_ff;
   logic [65:0]               len_ff;
   logic signed [66:0]        dot_ff;
   logic [99:0]               acc_ff;
   logic                      axis_ff;
   logic signed [33:0]        cx_ff;
   logic signed [33:0]        cy_ff;
   logic [65:0]               e2_ff;
   logic [30:0]               pen_ff;
   logic [33:0]               den_ff;
   logic signed [33:0]        vx_ff;
   logic signed [33:0]        vy_ff;
   logic signed [33:0]        pushx_ff;
   logic signed [33:0]        pushy_ff;
   logic                      rsp_valid_ff;
   csp_pkg::rsp_type          rsp_ff;

   logic signed [32:0]        dx, dy, rx, ry;
   logic signed [33:0]        ex, ey;
   logic [33:0]               dx_mag, dy_mag, rx_mag, ry_mag, ex_mag, ey_mag;
   logic [33:0]               d_axis_mag, v_axis_mag;
   logic                      d_axis_neg, v_axis_neg;
   logic [33:0]               mul_a, mul_b;
   logic signed [66:0]        prod_signed;
   logic [CW-1:0]             lim;
   logic [30:0]               pen_c;
   logic signed [33:0]        q_signed;
   logic                      req_fire;
   logic                      wr_en;
   logic                      rsp_load;

   csp_pkg::iter_ctl_type     iter_ctl;
   csp_pkg::iter_sts_type     iter_sts;
   logic [csp_pkg::NUM_W-1:0] iter_num;
   logic [csp_pkg::DEN_W-1:0] iter_den;
   logic [33:0]               iter_q;

   csp_iter u_iter (
      .clock  (clock),
      .reset  (reset),
      .ctl    (iter_ctl),
      .num    (iter_num),
      .den    (iter_den),
      .sts    (iter_sts),
      .result (iter_q)
   );

   assign req_ready = (state_ff == S_IDLE);
   assign req_fire = req_valid && req_ready;
   assign wr_en = req_fire && (req_data.func == csp_pkg::FUNC_WRITE)
                  && (32'(req_data.wall_slot) < 32'(MAX_WALLS));

   assign lim = (32'(count_ff) > 32'(MAX_WALLS)) ? CW'(MAX_WALLS) : CW'(count_ff);

   assign dx = {rd_ff.bx[31], rd_ff.bx} - {rd_ff.ax[31], rd_ff.ax};
   assign dy = {rd_ff.by[31], rd_ff.by} - {rd_ff.ay[31], rd_ff.ay};
   assign rx = {px_ff[31], px_ff} - {rd_ff.ax[31], rd_ff.ax};
   assign ry = {py_ff[31], py_ff} - {rd_ff.ay[31], rd_ff.ay};
   assign ex = {{2{px_ff[31]}}, px_ff} - cx_ff;
   assign ey = {{2{py_ff[31]}}, py_ff} - cy_ff;

   assign dx_mag = csp_pkg::mag34({dx[32], dx});
   assign dy_mag = csp_pkg::mag34({dy[32], dy});
   assign rx_mag = csp_pkg::mag34({rx[32], rx});
   assign ry_mag = csp_pkg::mag34({ry[32], ry});
   assign ex_mag = csp_pkg::mag34(ex);
   assign ey_mag = csp_pkg::mag34(ey);

   assign d_axis_mag = axis_ff ? dy_mag : dx_mag;
   assign d_axis_neg = axis_ff ? dy[32] : dx[32];
   assign v_axis_mag = axis_ff ? csp_pkg::mag34(vy_ff) : csp_pkg::mag34(vx_ff);
   assign v_axis_neg = axis_ff ? vy_ff[33] : vx_ff[33];

   assign pen_c = radius_ff - iter_q[30:0];

   always_comb begin
      prod_signed = $signed(prod_ff[66:0]);
      case (state_ff)
         S_DY: prod_signed = (rx[32] ^ dx[32]) ? -$signed(prod_ff[66:0])
                                               : $signed(prod_ff[66:0]);
         S_DSUM: prod_signed = (ry[32] ^ dy[32]) ? -$signed(prod_ff[66:0])
                                                 : $signed(prod_ff[66:0]);
         default: prod_signed = $signed(prod_ff[66:0]);
      endcase
   end

   always_comb begin
      q_signed = d_axis_neg ? $signed(34'd0 - iter_q) : $signed(iter_q);
      case (state_ff)
         S_PWAIT: q_signed = v_axis_neg ? $signed(34'd0 - iter_q) : $signed(iter_q);
         default: q_signed = d_axis_neg ? $signed(34'd0 - iter_q) : $signed(iter_q);
      endcase
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_LXX: begin
            mul_a = dx_mag;
            mul_b = dx_mag;
         end
         S_LYY: begin
            mul_a = dy_mag;
            mul_b = dy_mag;
         end
         S_DX: begin
            mul_a = rx_mag;
            mul_b = dx_mag;
         end
         S_DY: begin
            mul_a = ry_mag;
            mul_b = dy_mag;
         end
         S_OLO: begin
            mul_a = dot_ff[33:0];
            mul_b = d_axis_mag;
         end
         S_OHI: begin
            mul_a = {2'b00, dot_ff[65:34]};
            mul_b = d_axis_mag;
         end
         S_EX: begin
            mul_a = ex_mag;
            mul_b = ex_mag;
         end
         S_EY: begin
            mul_a = ey_mag;
            mul_b = ey_mag;
         end
         S_RR: begin
            mul_a = {3'b000, radius_ff};
            mul_b = {3'b000, radius_ff};
         end
         S_PMUL: begin
            mul_a = v_axis_mag;
            mul_b = {3'b000, pen_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      iter_ctl.start = 1'b0;
      iter_ctl.mode = csp_pkg::ITER_DIV;
      iter_num = '0;
      iter_den = '0;
      case (state_ff)
         S_ODIV: begin
            iter_ctl.start = 1'b1;
            iter_num = acc_ff + {prod_ff[65:0], 34'd0};
            iter_den = len_ff;
         end
         S_HIT: begin
            iter_ctl.start = (e2_ff < prod_ff[65:0]) && (prod_ff[67:66] == 2'b00);
            iter_ctl.mode = csp_pkg::ITER_SQRT;
            iter_num = {34'd0, e2_ff};
         end
         S_DWAIT: begin
            iter_ctl.start = iter_sts.done && (iter_q == '0)
                             && !(px_ff == rd_ff.ax && py_ff == rd_ff.ay) && (len_ff != '0);
            iter_ctl.mode = csp_pkg::ITER_SQRT;
            iter_num = {34'd0, len_ff};
         end
         S_PDIV: begin
            iter_ctl.start = 1'b1;
            iter_num = 100'(prod_ff);
            iter_den = {32'd0, den_ff};
         end
         default: begin
            iter_ctl.start = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(req_data.wall_slot)] <= '{ax: req_data.start_x, ay: req_data.start_y,
                                          bx: req_data.end_x, by: req_data.end_y,
                                          solid: req_data.solid};
      end
      rd_ff <= mem[idx_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         radius_ff <= 31'd16384;
         count_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            csp_pkg::CSR_RADIUS: radius_ff <= csr_wdata;
            csp_pkg::CSR_WALL_COUNT: count_ff <= csr_wdata[6:0];
            default: ;
         endcase
      end
   end

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || rsp_ready);

   always_ff @(posedge clock) begin
      prod_ff <= mul_a * mul_b;
      if (reset) begin
         state_ff <= S_IDLE;
         idx_ff <= '0;
         hit_ff <= 1'b0;
         axis_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
            rsp_ff <= '{resolved_x: px_ff, resolved_y: py_ff, hit: hit_ff};
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (req_fire && req_data.func == csp_pkg::FUNC_RESOLVE) begin
                  px_ff <= req_data.target_x;
                  py_ff <= req_data.target_y;
                  hit_ff <= 1'b0;
                  idx_ff <= '0;
                  state_ff <= S_FETCH;
               end
            end
            S_FETCH: state_ff <= S_CHECK;
            S_CHECK: begin
               if (idx_ff == lim) begin
                  state_ff <= S_DONE;
               end else if (!rd_ff.solid) begin
                  idx_ff <= idx_ff + CW'(1);
                  state_ff <= S_FETCH;
               end else begin
                  state_ff <= S_LXX;
               end
            end
            S_LXX: state_ff <= S_LYY;
            S_LYY: begin
               len_ff <= prod_ff[65:0];
               state_ff <= S_DX;
            end
            S_DX: begin
               len_ff <= len_ff + prod_ff[65:0];
               state_ff <= S_DY;
            end
            S_DY: begin
               dot_ff <= prod_signed;
               state_ff <= S_DSUM;
            end
            S_DSUM: begin
               dot_ff <= dot_ff + prod_signed;
               state_ff <= S_CLOSE;
            end
            S_CLOSE: begin
               if (len_ff == '0 || dot_ff[66] || dot_ff == '0) begin
                  cx_ff <= {{2{rd_ff.ax[31]}}, rd_ff.ax};
                  cy_ff <= {{2{rd_ff.ay[31]}}, rd_ff.ay};
                  state_ff <= S_EX;
               end else if (dot_ff[65:0] >= len_ff) begin
                  cx_ff <= {{2{rd_ff.bx[31]}}, rd_ff.bx};
                  cy_ff <= {{2{rd_ff.by[31]}}, rd_ff.by};
                  state_ff <= S_EX;
               end else begin
                  axis_ff <= 1'b0;
                  state_ff <= S_OLO;
               end
            end
            S_OLO: state_ff <= S_OHI;
            S_OHI: begin
               acc_ff <= 100'(prod_ff);
               state_ff <= S_ODIV;
            end
            S_ODIV: state_ff <= S_OWAIT;
            S_OWAIT: begin
               if (iter_sts.done) begin
                  if (!axis_ff) begin
                     cx_ff <= {{2{rd_ff.ax[31]}}, rd_ff.ax} + q_signed;
                     axis_ff <= 1'b1;
                     state_ff <= S_OLO;
                  end else begin
                     cy_ff <= {{2{rd_ff.ay[31]}}, rd_ff.ay} + q_signed;
                     state_ff <= S_EX;
                  end
               end
            end
            S_EX: state_ff <= S_EY;
            S_EY: begin
               e2_ff <= prod_ff[65:0];
               state_ff <= S_RR;
            end
            S_RR: begin
               e2_ff <= e2_ff + prod_ff[65:0];
               state_ff <= S_HIT;
            end
            S_HIT: begin
               if (iter_ctl.start) begin
                  hit_ff <= 1'b1;
                  state_ff <= S_DWAIT;
               end else begin
                  idx_ff <= idx_ff + CW'(1);
                  state_ff <= S_FETCH;
               end
            end
            S_DWAIT: begin
               if (iter_sts.done) begin
                  pen_ff <= pen_c;
                  axis_ff <= 1'b0;
                  if (iter_q != '0) begin
                     den_ff <= iter_q;
                     vx_ff <= ex;
                     vy_ff <= ey;
                     state_ff <= S_PMUL;
                  end else if (iter_ctl.start) begin
                     state_ff <= S_NWAIT;
                  end else begin
                     pushx_ff <= {3'b000, pen_c};
                     pushy_ff <= '0;
                     state_ff <= S_APPLY;
                  end
               end
            end
            S_NWAIT: begin
               if (iter_sts.done) begin
                  den_ff <= iter_q;
                  vx_ff <= {dy[32], dy};
                  vy_ff <= -{dx[32], dx};
                  state_ff <= S_PMUL;
               end
            end
            S_PMUL: state_ff <= S_PDIV;
            S_PDIV: state_ff <= S_PWAIT;
            S_PWAIT: begin
               if (iter_sts.done) begin
                  if (!axis_ff) begin
                     pushx_ff <= q_signed;
                     axis_ff <= 1'b1;
                     state_ff <= S_PMUL;
                  end else begin
                     pushy_ff <= q_signed;
                     state_ff <= S_APPLY;
                  end
               end
            end
            S_APPLY: begin
               px_ff <= csp_pkg::sat32({{3{px_ff[31]}}, px_ff} + {pushx_ff[33], pushx_ff});
               py_ff <= csp_pkg::sat32({{3{py_ff[31]}}, py_ff} + {pushy_ff[33], pushy_ff});
               idx_ff <= idx_ff + CW'(1);
               state_ff <= S_FETCH;
            end
            S_DONE: begin
               if (rsp_load) begin
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data = rsp_ff;

   // The shared unit is never restarted while a step sequence is still running.
   assert property (@(posedge clock) disable iff (reset) iter_ctl.start |-> !iter_sts.busy)
      else $error("iterative unit started while busy");

   // A finished divide or square root is only reported while the sequencer waits for it.
   assert property (@(posedge clock) disable iff (reset)
      iter_sts.done |-> (state_ff == S_OWAIT || state_ff == S_DWAIT
                         || state_ff == S_NWAIT || state_ff == S_PWAIT))
      else $error("iterative result arrived outside a wait state");

   // A push is only applied after a penetration was flagged.
   assert property (@(posedge clock) disable iff (reset) state_ff == S_APPLY |-> hit_ff)
      else $error("push applied without a hit");

   // The slot walk never passes the active wall count.
   assert property (@(posedge clock) disable iff (reset) state_ff == S_CHECK |-> idx_ff <= lim)
      else $error("slot index beyond wall count");

endmodule

@@ hdl/csp_iter.sv @@
// Shared iterative unit: restoring division or integer square root, one step per cycle.
module csp_iter (
   input  logic                        clock,
   input  logic                        reset,
   input  csp_pkg::iter_ctl_type       ctl,
   input  logic [csp_pkg::NUM_W-1:0]   num,
   input  logic [csp_pkg::DEN_W-1:0]   den,
   output csp_pkg::iter_sts_type       sts,
   output logic [33:0]                 result
);

   logic                          busy_ff;
   logic                          done_ff;
   logic [5:0]                    cnt_ff;
   csp_pkg::iter_mode_type        mode_ff;
   logic [65:0]                   rem_ff;
   logic [67:0]                   sh_ff;
   logic [33:0]                   q_ff;
   logic [65:0]                   den_ff;

   logic [66:0] div_t;
   logic        div_ge;
   logic [37:0] sq_t;
   logic [37:0] sq_trial;
   logic        sq_ge;

   assign div_t = {rem_ff, sh_ff[67]};
   assign div_ge = div_t >= {1'b0, den_ff};
   assign sq_t = {rem_ff[35:0], sh_ff[67:66]};
   assign sq_trial = {2'b00, q_ff, 2'b01};
   assign sq_ge = sq_t >= sq_trial;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         done_ff <= 1'b0;
         if (ctl.start) begin
            busy_ff <= 1'b1;
            cnt_ff <= 6'(csp_pkg::ITER_STEPS - 1);
            mode_ff <= ctl.mode;
            q_ff <= '0;
            den_ff <= den;
            if (ctl.mode == csp_pkg::ITER_DIV) begin
               rem_ff <= num[99:34];
               sh_ff <= {num[33:0], 34'd0};
            end else begin
               rem_ff <= '0;
               sh_ff <= num[67:0];
            end
         end else if (busy_ff) begin
            if (mode_ff == csp_pkg::ITER_DIV) begin
               rem_ff <= div_ge ? 66'(div_t - {1'b0, den_ff}) : div_t[65:0];
               q_ff <= {q_ff[32:0], div_ge};
               sh_ff <= {sh_ff[66:0], 1'b0};
            end else begin
               rem_ff <= sq_ge ? 66'(sq_t - sq_trial) : 66'(sq_t);
               q_ff <= {q_ff[32:0], sq_ge};
               sh_ff <= {sh_ff[65:0], 2'b00};
            end
            if (cnt_ff == '0) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end else begin
               cnt_ff <= cnt_ff - 6'd1;
            end
         end
      end
   end

   assign sts.busy = busy_ff;
   assign sts.done = done_ff;
   assign result = q_ff;

endmodule
